[src/bci_pkg.sv]
package bci_pkg;

  // Defaults for the top-level parameters.
  localparam int BCI_MAX_BLOCK_LEN = 16384;
  localparam int BCI_SAMPLE_WIDTH  = 16;
  localparam int BCI_MAX_BLOCKS    = 128;

  // Fixed field and register widths.
  localparam int VALUE_W   = 16;
  localparam int QM_W      = 4;
  localparam int COUNT_W   = 8;
  localparam int LEN_CFG_W = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  localparam logic [QM_W-1:0] QM_LIMIT = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BITS_PER_SYMBOL   = 3'd0,
    CFG_BLOCK_COUNT       = 3'd1,
    CFG_FIRST_GROUP_COUNT = 3'd2,
    CFG_FIRST_LENGTH      = 3'd3,
    CFG_REST_LENGTH       = 3'd4,
    CFG_DIRECTION         = 3'd5
  } cfg_idx_t;

  // Status of the write-address unit towards the top level.
  typedef struct packed {
    logic busy;        // setup pass running, no request may be taken
    logic last_elem;   // a push now completes the current block
    logic last_block;  // the current block is the last of the frame
  } wr_stat_t;

endpackage

[src/bci_div.sv]
module bci_div
  import bci_pkg::*;
#(
  parameter int W = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;
  logic [W:0]       trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // A result that finishes just as a new division starts belongs to the
  // abandoned one and is not reported.
  assign done = done_r && !start;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

[src/bci_ram.sv]
module bci_ram
  import bci_pkg::*;
#(
  parameter int DEPTH = 2 * BCI_MAX_BLOCK_LEN,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = BCI_SAMPLE_WIDTH
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/bci_wadr.sv]
module bci_wadr
  import bci_pkg::*;
#(
  parameter int MAX_BLOCK_LEN = BCI_MAX_BLOCK_LEN,
  parameter int LEN_W         = $clog2(MAX_BLOCK_LEN + 1),
  parameter int ADDR_W        = $clog2(MAX_BLOCK_LEN)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr,
  input  logic [QM_W-1:0]    qm,
  input  logic [LEN_W-1:0]   len1,
  input  logic [LEN_W-1:0]   len2,
  input  logic               dir,
  input  logic [COUNT_W-1:0] first_cnt,
  input  logic [COUNT_W-1:0] blk_cnt,
  input  logic               push,
  output wr_stat_t           stat,
  output logic [ADDR_W-1:0]  waddr,
  output logic [LEN_W-1:0]   blk_len
);

  localparam int PROD_W = LEN_W + QM_W;

  typedef enum logic [6:0] {
    ST_RUN  = 7'b0000001,
    ST_R1   = 7'b0000010,
    ST_R2   = 7'b0000100,
    ST_PROD = 7'b0001000,
    ST_CHK  = 7'b0010000,
    ST_DIVQ = 7'b0100000,
    ST_FIX  = 7'b1000000
  } seq_state_t;

  seq_state_t         state_r, state_nxt;
  logic               go_r, go_nxt;
  logic [LEN_W-1:0]   r1_r, r1_nxt, r2_r, r2_nxt;
  logic [LEN_W-1:0]   p1_r, p1_nxt, p2_r, p2_nxt;
  logic [LEN_W-1:0]   wq_r, wq_nxt;
  logic [QM_W-1:0]    wrow_r, wrow_nxt;
  logic [LEN_W-1:0]   wcol_r, wcol_nxt;
  logic [ADDR_W-1:0]  waddr_r, waddr_nxt;
  logic [COUNT_W-1:0] bidx_r, bidx_nxt;

  logic               first_grp;
  logic [LEN_W-1:0]   e_cur, r_cur, p_cur;
  logic [LEN_W:0]     nq;
  logic               last_elem, last_block;
  logic [LEN_W-1:0]   col_inc;
  logic [QM_W-1:0]    row_inc;
  logic [PROD_W-1:0]  fix_addr;

  logic               div_done;
  logic [LEN_W-1:0]   div_dividend, div_divisor, div_quot, div_rem;

  assign first_grp  = bidx_r < first_cnt;
  assign e_cur      = first_grp ? len1 : len2;
  assign r_cur      = first_grp ? r1_r : r2_r;
  assign p_cur      = first_grp ? p1_r : p2_r;
  assign nq         = {1'b0, wq_r} + 1'b1;
  assign last_elem  = nq >= {1'b0, e_cur};
  assign last_block = ({1'b0, bidx_r} + 1'b1) >= {1'b0, blk_cnt};
  assign col_inc    = wcol_r + 1'b1;
  assign row_inc    = wrow_r + 1'b1;
  assign fix_addr   = dir ? (PROD_W'(wrow_r) * PROD_W'(r_cur) + PROD_W'(wcol_r))
                          : (PROD_W'(wcol_r) * PROD_W'(qm) + PROD_W'(wrow_r));

  always_comb begin
    case (state_r)
      ST_R1: begin
        div_dividend = len1;
        div_divisor  = LEN_W'(qm);
      end
      ST_R2: begin
        div_dividend = len2;
        div_divisor  = LEN_W'(qm);
      end
      default: begin
        div_dividend = wq_r;
        div_divisor  = dir ? LEN_W'(qm) : r_cur;
      end
    endcase
  end

  bci_div #(
    .W(LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    go_nxt    = 1'b0;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    wq_nxt    = wq_r;
    wrow_nxt  = wrow_r;
    wcol_nxt  = wcol_r;
    waddr_nxt = waddr_r;
    bidx_nxt  = bidx_r;

    if (cfg_wr) begin
      state_nxt = ST_R1;
      go_nxt    = 1'b1;
    end else begin
      case (state_r)
        ST_RUN: begin
          if (push) begin
            if (last_elem) begin
              wq_nxt    = '0;
              wrow_nxt  = '0;
              wcol_nxt  = '0;
              waddr_nxt = '0;
              bidx_nxt  = last_block ? '0 : bidx_r + 1'b1;
            end else begin
              wq_nxt = nq[LEN_W-1:0];
              if (nq >= {1'b0, p_cur}) begin
                // Tail beyond the full matrix keeps its position.
                waddr_nxt = ADDR_W'(nq);
              end else if (!dir) begin
                if (col_inc == r_cur) begin
                  wcol_nxt  = '0;
                  wrow_nxt  = row_inc;
                  waddr_nxt = ADDR_W'(row_inc);
                end else begin
                  wcol_nxt  = col_inc;
                  waddr_nxt = waddr_r + ADDR_W'(qm);
                end
              end else begin
                if (row_inc == qm) begin
                  wrow_nxt  = '0;
                  wcol_nxt  = col_inc;
                  waddr_nxt = ADDR_W'(col_inc);
                end else begin
                  wrow_nxt  = row_inc;
                  waddr_nxt = waddr_r + ADDR_W'(r_cur);
                end
              end
            end
          end
        end
        ST_R1: begin
          if (div_done) begin
            r1_nxt    = div_quot;
            state_nxt = ST_R2;
            go_nxt    = 1'b1;
          end
        end
        ST_R2: begin
          if (div_done) begin
            r2_nxt    = div_quot;
            state_nxt = ST_PROD;
          end
        end
        ST_PROD: begin
          p1_nxt    = LEN_W'(PROD_W'(qm) * PROD_W'(r1_r));
          p2_nxt    = LEN_W'(PROD_W'(qm) * PROD_W'(r2_r));
          state_nxt = ST_CHK;
        end
        ST_CHK: begin
          // Rebuild row, column and address of a partly written block.
          if (wq_r >= p_cur || wq_r == '0) begin
            wrow_nxt  = '0;
            wcol_nxt  = '0;
            waddr_nxt = ADDR_W'(wq_r);
            state_nxt = ST_RUN;
          end else begin
            go_nxt    = 1'b1;
            state_nxt = ST_DIVQ;
          end
        end
        ST_DIVQ: begin
          if (div_done) begin
            if (!dir) begin
              wrow_nxt = QM_W'(div_quot);
              wcol_nxt = div_rem;
            end else begin
              wcol_nxt = div_quot;
              wrow_nxt = QM_W'(div_rem);
            end
            state_nxt = ST_FIX;
          end
        end
        ST_FIX: begin
          waddr_nxt = ADDR_W'(fix_addr);
          state_nxt = ST_RUN;
        end
        default: begin
          state_nxt = ST_R1;
          go_nxt    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_R1;
      go_r    <= 1'b1;
      wq_r    <= '0;
      wrow_r  <= '0;
      wcol_r  <= '0;
      waddr_r <= '0;
      bidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      wq_r    <= wq_nxt;
      wrow_r  <= wrow_nxt;
      wcol_r  <= wcol_nxt;
      waddr_r <= waddr_nxt;
      bidx_r  <= bidx_nxt;
    end
    r1_r <= r1_nxt;
    r2_r <= r2_nxt;
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end

  assign stat.busy       = (state_r != ST_RUN) || go_r;
  assign stat.last_elem  = last_elem;
  assign stat.last_block = last_block;
  assign waddr           = waddr_r;
  assign blk_len         = e_cur;

endmodule

[src/row_column_bit_interleaver_top.sv]
// Row-column block interleaver with two sample banks. A push request writes
// its sample straight to the permuted address in the write bank while the
// previous block drains from the other bank in address order, so the block
// takes one request per clock cycle unless the setup pass, a configuration
// write or a full output queue holds it off, and each request that finds a
// block pending yields one result, registered at the RAM output and then in
// a four-entry output queue. Flush requests only drain. After reset and after
// every configuration write, a setup pass computes the matrix widths (and the
// position inside a partly written block) with a shared bit-serial divider;
// no request is taken while it runs. Configuration writes are accepted at any
// time; no request is taken in the cycle of a write.
module row_column_bit_interleaver_top
  import bci_pkg::*;
#(
  parameter int MAX_BLOCK_LEN = BCI_MAX_BLOCK_LEN,
  parameter int SAMPLE_WIDTH  = BCI_SAMPLE_WIDTH,
  parameter int MAX_BLOCKS    = BCI_MAX_BLOCKS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_block_end,
  output logic                      out_frame_end,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int LEN_W   = $clog2(MAX_BLOCK_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_BLOCK_LEN);
  localparam int MEM_DEP = 2 * MAX_BLOCK_LEN;
  localparam int MEM_AW  = $clog2(MEM_DEP);
  localparam int MEM_DW  = (SAMPLE_WIDTH < VALUE_W) ? SAMPLE_WIDTH : VALUE_W;
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);
  localparam logic [COUNT_W:0] BLK_CAP =
    (MAX_BLOCKS > 255) ? (COUNT_W+1)'(255) : (COUNT_W+1)'(MAX_BLOCKS);

  // Configuration registers.
  logic [QM_W-1:0]      qm_r;
  logic [COUNT_W-1:0]   bcnt_r, fgc_r;
  logic [LEN_CFG_W-1:0] len1_r, len2_r;
  logic                 dir_r;

  logic [QM_W-1:0]      qm_eff;
  logic [COUNT_W-1:0]   bcnt_eff;
  logic [LEN_W-1:0]     len1_eff, len2_eff;

  // Read side of the ping-pong buffer.
  logic                 wb_r, wb_nxt;
  logic [LEN_W-1:0]     rc_r, rc_nxt;
  logic [LEN_W-1:0]     plen_r, plen_nxt;
  logic                 pfin_r, pfin_nxt;

  // Read in flight, and the output queue.
  logic                 s1_v_r, s1_be_r, s1_fe_r;
  logic [MEM_DW-1:0]    q_val_r [Q_DEPTH];
  logic                 q_be_r  [Q_DEPTH];
  logic                 q_fe_r  [Q_DEPTH];
  logic [QP_W-1:0]      q_wp_r, q_rp_r;
  logic [QC_W-1:0]      q_cnt_r;

  logic                 accept, emit, push, last_rd, pop;
  logic [LEN_W:0]       rc_inc;
  wr_stat_t             wstat;
  logic [ADDR_W-1:0]    waddr;
  logic [LEN_W-1:0]     blk_len;
  logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
  logic [MEM_DW-1:0]    mem_rdata;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_CFG_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (32'(len) > 32'(MAX_BLOCK_LEN)) begin
      res = LEN_W'(MAX_BLOCK_LEN);
    end else begin
      res = LEN_W'(len);
    end
    return res;
  endfunction

  always_comb begin
    if (qm_r == '0) begin
      qm_eff = QM_W'(1);
    end else if (qm_r > QM_LIMIT) begin
      qm_eff = QM_LIMIT;
    end else begin
      qm_eff = qm_r;
    end
    if (bcnt_r == '0) begin
      bcnt_eff = COUNT_W'(1);
    end else if ({1'b0, bcnt_r} > BLK_CAP) begin
      bcnt_eff = BLK_CAP[COUNT_W-1:0];
    end else begin
      bcnt_eff = bcnt_r;
    end
  end

  assign len1_eff = clamp_len(len1_r);
  assign len2_eff = clamp_len(len2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r   <= QM_W'(2);
      bcnt_r <= COUNT_W'(1);
      fgc_r  <= '0;
      len1_r <= LEN_CFG_W'(16);
      len2_r <= LEN_CFG_W'(16);
      dir_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BITS_PER_SYMBOL:   qm_r   <= cfg_data[QM_W-1:0];
        CFG_BLOCK_COUNT:       bcnt_r <= cfg_data[COUNT_W-1:0];
        CFG_FIRST_GROUP_COUNT: fgc_r  <= cfg_data[COUNT_W-1:0];
        CFG_FIRST_LENGTH:      len1_r <= cfg_data[LEN_CFG_W-1:0];
        CFG_REST_LENGTH:       len2_r <= cfg_data[LEN_CFG_W-1:0];
        CFG_DIRECTION:         dir_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  bci_wadr #(
    .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
    .LEN_W         (LEN_W),
    .ADDR_W        (ADDR_W)
  ) u_wadr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_we),
    .qm        (qm_eff),
    .len1      (len1_eff),
    .len2      (len2_eff),
    .dir       (dir_r),
    .first_cnt (fgc_r),
    .blk_cnt   (bcnt_eff),
    .push      (push),
    .stat      (wstat),
    .waddr     (waddr),
    .blk_len   (blk_len)
  );

  // Room is kept in the queue for the read in flight as well.
  assign in_ready = !wstat.busy && !cfg_we
                    && ((QC_W+1)'(q_cnt_r) + (QC_W+1)'(s1_v_r) < (QC_W+1)'(Q_DEPTH));
  assign accept   = in_valid && in_ready;
  assign emit     = accept && (plen_r != '0);
  assign push     = accept && !in_action;
  assign rc_inc   = {1'b0, rc_r} + 1'b1;
  assign last_rd  = rc_inc >= {1'b0, plen_r};

  // Reads always hit the bank opposite to the one written in the same
  // cycle, so the two ports never collide on one entry.
  assign mem_raddr = wb_r ? MEM_AW'(rc_r)
                          : MEM_AW'(MAX_BLOCK_LEN) + MEM_AW'(rc_r);
  assign mem_waddr = wb_r ? MEM_AW'(MAX_BLOCK_LEN) + MEM_AW'(waddr)
                          : MEM_AW'(waddr);

  bci_ram #(
    .DEPTH (MEM_DEP),
    .AW    (MEM_AW),
    .DW    (MEM_DW)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (mem_waddr),
    .wdata (in_value[MEM_DW-1:0]),
    .re    (emit),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    wb_nxt   = wb_r;
    rc_nxt   = rc_r;
    plen_nxt = plen_r;
    pfin_nxt = pfin_r;
    if (emit) begin
      if (last_rd) begin
        rc_nxt   = '0;
        plen_nxt = '0;
        pfin_nxt = 1'b0;
      end else begin
        rc_nxt = rc_inc[LEN_W-1:0];
      end
    end
    // A block completed by this push replaces anything still draining.
    if (push && wstat.last_elem) begin
      wb_nxt   = !wb_r;
      rc_nxt   = '0;
      plen_nxt = blk_len;
      pfin_nxt = wstat.last_block;
    end
  end

  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r    <= 1'b0;
      rc_r    <= '0;
      plen_r  <= '0;
      pfin_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      wb_r    <= wb_nxt;
      rc_r    <= rc_nxt;
      plen_r  <= plen_nxt;
      pfin_r  <= pfin_nxt;
      s1_v_r  <= emit;
      if (s1_v_r) begin
        q_wp_r <= q_wp_r + 1'b1;
      end
      if (pop) begin
        q_rp_r <= q_rp_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + QC_W'(s1_v_r) - QC_W'(pop);
    end
    s1_be_r <= last_rd;
    s1_fe_r <= last_rd && pfin_r;
    if (s1_v_r) begin
      q_val_r[q_wp_r] <= mem_rdata;
      q_be_r[q_wp_r]  <= s1_be_r;
      q_fe_r[q_wp_r]  <= s1_fe_r;
    end
  end

  assign out_valid     = q_cnt_r != '0;
  assign out_value     = VALUE_W'(q_val_r[q_rp_r]);
  assign out_block_end = q_be_r[q_rp_r];
  assign out_frame_end = q_fe_r[q_rp_r];

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import bci_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PUSHES = 700;

  typedef enum bit {REQ_PUSH = 1'b0, REQ_FLUSH = 1'b1} request_kind_t;
  localparam bit DIR_INTERLEAVE   = 1'b0;
  localparam bit DIR_DEINTERLEAVE = 1'b1;

  localparam logic signed [VALUE_W-1:0] EDGE_VALUES [10] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
    16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh7FFE
  };

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    bit                        block_end;
    bit                        frame_end;
  } drained_sample_t;

  class interleave_predictor;
    logic signed [VALUE_W-1:0] bank_mem [2*BCI_MAX_BLOCK_LEN];
    logic [QM_W-1:0]      qm_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   first_count_reg;
    logic [LEN_CFG_W-1:0] first_len_reg;
    logic [LEN_CFG_W-1:0] rest_len_reg;
    bit                   dir_reg;
    bit                   wr_bank;
    logic [LEN_CFG_W-1:0] wr_count;
    logic [LEN_CFG_W-1:0] rd_count;
    logic [LEN_CFG_W-1:0] pend_len;
    logic [COUNT_W-1:0]   blk_idx;
    bit                   pend_last;
    drained_sample_t      awaited_samples [$];
    int unsigned          errors;

    function new();
      qm_reg          = 4'd2;
      count_reg       = 8'd1;
      first_count_reg = 8'd0;
      first_len_reg   = 15'd16;
      rest_len_reg    = 15'd16;
      dir_reg         = DIR_INTERLEAVE;
      wr_bank         = 1'b0;
      wr_count        = '0;
      rd_count        = '0;
      pend_len        = '0;
      blk_idx         = '0;
      pend_last       = 1'b0;
      errors          = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_BITS_PER_SYMBOL:   qm_reg = data[QM_W-1:0];
        CFG_BLOCK_COUNT:       count_reg = data[COUNT_W-1:0];
        CFG_FIRST_GROUP_COUNT: first_count_reg = data[COUNT_W-1:0];
        CFG_FIRST_LENGTH:      first_len_reg = data[LEN_CFG_W-1:0];
        CFG_REST_LENGTH:       rest_len_reg = data[LEN_CFG_W-1:0];
        CFG_DIRECTION:         dir_reg = data[0];
        default: ;
      endcase
    endfunction

    // The read side emits before the write side stores, so a block completed
    // by this push is only drained from the next request on.
    function void note_request(request_kind_t kind, logic signed [VALUE_W-1:0] sample);
      int unsigned     qm;
      int unsigned     len;
      int unsigned     cols;
      int unsigned     pos;
      int unsigned     addr;
      int unsigned     frame_blocks;
      drained_sample_t item;
      if (pend_len != 0) begin
        item.value = bank_mem[(wr_bank ? 0 : BCI_MAX_BLOCK_LEN) + int'(rd_count)];
        rd_count++;
        item.block_end = (rd_count >= pend_len);
        item.frame_end = item.block_end && pend_last;
        awaited_samples.push_back(item);
        if (item.block_end) begin
          pend_len  = '0;
          pend_last = 1'b0;
          rd_count  = '0;
        end
      end
      if (kind == REQ_FLUSH) return;

      qm = (qm_reg == 0) ? 1 : (qm_reg > QM_LIMIT) ? int'(QM_LIMIT) : int'(qm_reg);
      len = (blk_idx < first_count_reg) ? first_len_reg : rest_len_reg;
      if (len == 0) len = 1;
      else if (len > BCI_MAX_BLOCK_LEN) len = BCI_MAX_BLOCK_LEN;
      cols = len / qm;
      pos  = wr_count;
      addr = pos;
      // Elements past the last full column keep their position.
      if (cols != 0 && pos < qm * cols) begin
        if (dir_reg == DIR_INTERLEAVE) addr = (pos % cols) * qm + pos / cols;
        else addr = (pos % qm) * cols + pos / qm;
      end
      bank_mem[(wr_bank ? BCI_MAX_BLOCK_LEN : 0) + addr] = sample;
      wr_count++;
      if (wr_count >= len) begin
        frame_blocks = (count_reg == 0) ? 1 :
                       (count_reg > BCI_MAX_BLOCKS) ? BCI_MAX_BLOCKS : int'(count_reg);
        pend_last = (int'(blk_idx) + 1 >= frame_blocks);
        wr_bank   = !wr_bank;
        pend_len  = LEN_CFG_W'(len);
        rd_count  = '0;
        blk_idx   = pend_last ? '0 : blk_idx + 1'b1;
        wr_count  = '0;
      end
    endfunction

    function void check_sample(logic signed [VALUE_W-1:0] value, logic block_end,
                               logic frame_end);
      drained_sample_t want;
      if (awaited_samples.size() == 0) begin
        $error("result %0d arrived with no result outstanding", value);
        errors++;
        return;
      end
      want = awaited_samples.pop_front();
      if (value !== want.value) begin
        $error("out_value: expected %0d, got %0d", want.value, value);
        errors++;
      end
      if (block_end !== want.block_end) begin
        $error("out_block_end: expected %0d, got %0d", want.block_end, block_end);
        errors++;
      end
      if (frame_end !== want.frame_end) begin
        $error("out_frame_end: expected %0d, got %0d", want.frame_end, frame_end);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_action = REQ_PUSH;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_block_end;
  logic                      out_frame_end;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_BITS_PER_SYMBOL;
  logic [CFG_W-1:0]          cfg_data = '0;

  interleave_predictor sb = new();

  bit          idle_on = 1'b1;
  int unsigned idle_div = 6;
  int unsigned flush_pct = 10;
  int unsigned pushes = 0;
  int unsigned stall_left = 0;

  row_column_bit_interleaver_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_block_end (out_block_end),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(50_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: check what was accepted at this edge, then pick the next ready.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_sample(out_value, out_block_end, out_frame_end);
    if (idle_on && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, idle_div - 1) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready  <= 1'b0;
    end else begin
      stall_left <= 0;
      out_ready  <= 1'b1;
    end
  end

  function automatic logic signed [VALUE_W-1:0] random_sample();
    if ($urandom_range(0, 5) == 0) return EDGE_VALUES[$urandom_range(0, 3)];
    return VALUE_W'($urandom());
  endfunction

  function automatic int unsigned pick_length(int unsigned qm);
    int unsigned q;
    q = (qm == 0) ? 1 : (qm > QM_LIMIT) ? int'(QM_LIMIT) : qm;
    case ($urandom_range(0, 11))
      0:       return 0;
      1, 2:    return $urandom_range(1, 64);
      default: return q * $urandom_range(1, 64 / q);
    endcase
  endfunction

  task automatic send_request(request_kind_t kind, logic signed [VALUE_W-1:0] sample);
    in_valid  <= 1'b1;
    in_action <= kind;
    in_value  <= sample;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(kind, sample);
    if (idle_on && $urandom_range(0, idle_div - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_register(cfg_idx_t idx, int unsigned data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_W-1:0];
    @(posedge clk);
    sb.set_register(idx, data[CFG_W-1:0]);
  endtask

  task automatic apply_settings(int unsigned qm, int unsigned blocks, int unsigned first_blocks,
                                int unsigned first_len, int unsigned rest_len, bit dir);
    write_register(CFG_BITS_PER_SYMBOL, qm);
    write_register(CFG_BLOCK_COUNT, blocks);
    write_register(CFG_FIRST_GROUP_COUNT, first_blocks);
    write_register(CFG_FIRST_LENGTH, first_len);
    write_register(CFG_REST_LENGTH, rest_len);
    write_register(CFG_DIRECTION, dir);
    cfg_we <= 1'b0;
  endtask

  // Lengths stay within 64 so that, once both banks hold 64 written samples,
  // a block cut short by a register change never reads an unwritten entry.
  task automatic random_settings();
    int unsigned qm;
    int unsigned blocks;
    int unsigned first_blocks;
    qm = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) qm = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
    blocks = $urandom_range(1, 6);
    case ($urandom_range(0, 11))
      0: blocks = 0;
      1: blocks = BCI_MAX_BLOCKS;
      2: blocks = $urandom_range(BCI_MAX_BLOCKS + 1, 255);
      default: ;
    endcase
    first_blocks = $urandom_range(0, 7);
    if ($urandom_range(0, 9) == 0) first_blocks = $urandom_range(BCI_MAX_BLOCKS, 255);
    apply_settings(qm, blocks, first_blocks, pick_length(qm), pick_length(qm),
                   $urandom_range(0, 1));
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.awaited_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic drain_pending();
    while (sb.pend_len != 0) send_request(REQ_FLUSH, random_sample());
    quiesce();
  endtask

  task automatic run_requests(int unsigned count, int pause_at);
    for (int k = 0; k < int'(count); k++) begin
      if (k == pause_at) quiesce();
      if ($urandom_range(0, 99) < flush_pct) begin
        send_request(REQ_FLUSH, random_sample());
      end else begin
        send_request(REQ_PUSH, random_sample());
        pushes++;
      end
    end
  endtask

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // A long block followed by a short one: the second one completes while the
    // first is still draining and takes its place.
    apply_settings(2, 2, 1, 6, 4, DIR_INTERLEAVE);
    for (int k = 0; k < 10; k++) send_request(REQ_PUSH, EDGE_VALUES[k]);
    repeat (5) send_request(REQ_FLUSH, EDGE_VALUES[0]);
    quiesce();

    // Inverse permutation on a length that leaves a partial column.
    apply_settings(3, 1, 0, 7, 7, DIR_DEINTERLEAVE);
    for (int k = 0; k < 7; k++) send_request(REQ_PUSH, EDGE_VALUES[9 - k]);
    drain_pending();
    send_request(REQ_FLUSH, EDGE_VALUES[1]);
    quiesce();

    // Fill both banks with two whole 64-sample blocks.
    apply_settings($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(0, 4), 64, 64,
                   $urandom_range(0, 1));
    repeat (128) send_request(REQ_PUSH, random_sample());
    pushes += 128;
    drain_pending();

    phase = 0;
    while (pushes < RANDOM_PUSHES) begin
      idle_on   = ($urandom_range(0, 3) != 0);
      flush_pct = $urandom_range(0, 30);
      if (phase == 2) begin
        // Unit-length blocks so that a full frame of the largest block count ends.
        flush_pct = 5;
        apply_settings($urandom_range(1, 8), 255, 0, 1, 1, $urandom_range(0, 1));
        run_requests(300, -1);
      end else begin
        random_settings();
        run_requests($urandom_range(30, 120), phase == 1 ? $urandom_range(5, 25) : -1);
      end
      drain_pending();
      phase++;
    end

    idle_on   = 1'b0;
    idle_div  = 6;
    flush_pct = 10;
    random_settings();
    run_requests(80, -1);
    drain_pending();

    if (sb.errors == 0 && sb.awaited_samples.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
